@@ hdl/jtag_tap_scan_sequencer_defines.svh @@
// Assertion macros for the JTAG TAP scan sequencer.
`ifndef JTAG_TAP_SCAN_SEQUENCER_DEFINES_SVH
`define JTAG_TAP_SCAN_SEQUENCER_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is asserted.
`define JTSQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define JTSQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define JTSQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define JTSQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ hdl/jtsq_pkg.sv @@
// Types and constants shared by the JTAG TAP scan sequencer.
`timescale 1ns / 1ps
`default_nettype none
package jtsq_pkg;

    localparam int MAX_SCAN_BITS = 64;
    localparam int MAX_TMS_BITS  = 31;

    // Request opcodes; codes five to seven are ignored: no clock and status ok, also while busy.
    localparam logic [2:0] OP_TICK    = 3'd0;
    localparam logic [2:0] OP_DR_SCAN = 3'd1;
    localparam logic [2:0] OP_IR_SCAN = 3'd2;
    localparam logic [2:0] OP_TAP_RST = 3'd3;
    localparam logic [2:0] OP_RAW_TMS = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_BUSY  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam logic [1:0] TAP_RESET    = 2'd0;
    localparam logic [1:0] TAP_IDLE     = 2'd1;
    localparam logic [1:0] TAP_PAUSE_DR = 2'd2;
    localparam logic [1:0] TAP_PAUSE_IR = 2'd3;

    // TMS walks into Shift-DR / Shift-IR and back out, and the walk to Test-Logic-Reset.
    localparam logic [31:0] TMS_DR_FROM_IDLE  = 32'h02;
    localparam logic [31:0] TMS_DR_FROM_PAUSE = 32'h07;
    localparam logic [31:0] TMS_IR_FROM_IDLE  = 32'h06;
    localparam logic [31:0] TMS_IR_FROM_PAUSE = 32'h0F;
    localparam logic [31:0] TMS_EXIT_IDLE     = 32'h01;
    localparam logic [31:0] TMS_EXIT_PAUSE    = 32'h00;
    localparam logic [31:0] TMS_TAP_RESET     = 32'h1F;

    localparam logic [5:0] LEN_DR_FROM_IDLE  = 6'd4;
    localparam logic [5:0] LEN_DR_FROM_PAUSE = 6'd5;
    localparam logic [5:0] LEN_IR_FROM_IDLE  = 6'd5;
    localparam logic [5:0] LEN_IR_FROM_PAUSE = 6'd6;
    localparam logic [5:0] LEN_EXIT_IDLE     = 6'd2;
    localparam logic [5:0] LEN_EXIT_PAUSE    = 6'd1;
    localparam logic [5:0] LEN_TAP_RESET     = 6'd5;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_ENTRY,
        PH_DATA,
        PH_EXIT
    } jtsq_phase_t;

    typedef struct packed {
        logic [1:0]  tracked_tap;
        jtsq_phase_t phase;
        logic [31:0] tms_pattern;
        logic [5:0]  tms_left;
        logic [63:0] tdi_shifter;
        logic [6:0]  data_left;
        logic [63:0] capture_reg;
        logic [5:0]  capture_pos;
        logic [1:0]  exit_target;
    } jtsq_state_t;

    typedef struct packed {
        logic        clock_pulse;
        logic        tms_level;
        logic        tdi_level;
        logic        busy_res;
        logic        finished;
        logic [1:0]  status;
        logic [63:0] captured_bits;
        logic [1:0]  tap_position;
    } jtsq_res_t;

endpackage
`default_nettype wire

@@ hdl/jtsq_step.sv @@
// Next-state and result logic for one request of the scan sequencer.
`timescale 1ns / 1ps
`default_nettype none
module jtsq_step
    import jtsq_pkg::*;
(
    input  wire logic [2:0]  op,
    input  wire logic [63:0] payload,
    input  wire logic [6:0]  bit_count,
    input  wire logic        end_in_pause,
    input  wire logic        tdo_sample,
    input  wire jtsq_state_t state,
    output jtsq_state_t      state_next,
    output jtsq_res_t        res
);

    logic [6:0] data_left_dec;
    logic [5:0] tms_left_dec;
    logic       from_pause;
    logic       busy_now;

    assign data_left_dec = state.data_left - 7'd1;
    assign tms_left_dec  = state.tms_left - 6'd1;
    assign from_pause    = (state.tracked_tap == TAP_PAUSE_DR) ||
                           (state.tracked_tap == TAP_PAUSE_IR);
    assign busy_now      = (state.phase != PH_IDLE);

    always_comb begin
        state_next      = state;
        res.clock_pulse = 1'b0;
        res.tms_level   = 1'b0;
        res.tdi_level   = 1'b0;
        res.finished    = 1'b0;
        res.status      = ST_OK;

        case (op)
            OP_TICK: begin
                case (state.phase)
                    PH_DATA: begin
                        res.clock_pulse        = 1'b1;
                        res.tdi_level          = state.tdi_shifter[0];
                        state_next.tdi_shifter = {1'b0, state.tdi_shifter[63:1]};
                        state_next.capture_reg = state.capture_reg |
                                                 (64'(tdo_sample) << state.capture_pos);
                        state_next.capture_pos = state.capture_pos + 6'd1;
                        state_next.data_left   = data_left_dec;
                        if (data_left_dec == '0) begin
                            // last data bit leaves Shift with TMS high
                            res.tms_level    = 1'b1;
                            state_next.phase = PH_EXIT;
                            if (state.exit_target == TAP_IDLE) begin
                                state_next.tms_pattern = TMS_EXIT_IDLE;
                                state_next.tms_left    = LEN_EXIT_IDLE;
                            end else begin
                                state_next.tms_pattern = TMS_EXIT_PAUSE;
                                state_next.tms_left    = LEN_EXIT_PAUSE;
                            end
                        end
                    end
                    PH_ENTRY, PH_EXIT: begin
                        res.clock_pulse        = 1'b1;
                        res.tms_level          = state.tms_pattern[0];
                        state_next.tms_pattern = {1'b0, state.tms_pattern[31:1]};
                        state_next.tms_left    = tms_left_dec;
                        if (tms_left_dec == '0) begin
                            if (state.phase == PH_ENTRY && state.data_left != '0) begin
                                state_next.phase = PH_DATA;
                            end else begin
                                state_next.phase       = PH_IDLE;
                                state_next.tracked_tap = state.exit_target;
                                res.finished           = 1'b1;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            OP_DR_SCAN, OP_IR_SCAN: begin
                if (busy_now) begin
                    res.status = ST_BUSY;
                end else if (bit_count == '0 || bit_count > 7'(MAX_SCAN_BITS)) begin
                    res.status = ST_RANGE;
                end else begin
                    if (op == OP_DR_SCAN) begin
                        state_next.tms_pattern = from_pause ? TMS_DR_FROM_PAUSE
                                                            : TMS_DR_FROM_IDLE;
                        state_next.tms_left    = from_pause ? LEN_DR_FROM_PAUSE
                                                            : LEN_DR_FROM_IDLE;
                        state_next.exit_target = end_in_pause ? TAP_PAUSE_DR : TAP_IDLE;
                    end else begin
                        state_next.tms_pattern = from_pause ? TMS_IR_FROM_PAUSE
                                                            : TMS_IR_FROM_IDLE;
                        state_next.tms_left    = from_pause ? LEN_IR_FROM_PAUSE
                                                            : LEN_IR_FROM_IDLE;
                        state_next.exit_target = end_in_pause ? TAP_PAUSE_IR : TAP_IDLE;
                    end
                    state_next.tdi_shifter = payload;
                    state_next.data_left   = bit_count;
                    state_next.capture_reg = '0;
                    state_next.capture_pos = '0;
                    state_next.phase       = PH_ENTRY;
                end
            end
            OP_TAP_RST: begin
                if (busy_now) begin
                    res.status = ST_BUSY;
                end else begin
                    state_next.tms_pattern = TMS_TAP_RESET;
                    state_next.tms_left    = LEN_TAP_RESET;
                    state_next.data_left   = '0;
                    state_next.exit_target = TAP_RESET;
                    state_next.phase       = PH_EXIT;
                end
            end
            OP_RAW_TMS: begin
                if (busy_now) begin
                    res.status = ST_BUSY;
                end else if (bit_count > 7'(MAX_TMS_BITS)) begin
                    res.status = ST_RANGE;
                end else if (bit_count != '0) begin
                    state_next.tms_pattern = payload[31:0];
                    state_next.tms_left    = bit_count[5:0];
                    state_next.data_left   = '0;
                    state_next.exit_target = state.tracked_tap;
                    state_next.phase       = PH_EXIT;
                end
            end
            default: begin
            end
        endcase

        res.busy_res      = (state_next.phase != PH_IDLE);
        res.captured_bits = state_next.capture_reg;
        res.tap_position  = state_next.tracked_tap;
    end

endmodule
`default_nettype wire

@@ hdl/jtag_tap_scan_sequencer.sv @@
// Top level of the JTAG TAP scan sequencer: request register, sequencer state, result register.
// Throughput: one request per cycle while the result register is not stalled by m_ready;
// each tick request while busy moves the TAP sequence by one TCK.
// The step logic between the request register and the result register is a single pass.
// Reset (aresetn low, synchronous) clears both valid flags and all sequencer state:
// tracked TAP is Test-Logic-Reset, the sequencer is idle and the capture register is zero.
`timescale 1ns / 1ps
`default_nettype none
`include "jtag_tap_scan_sequencer_defines.svh"
module jtag_tap_scan_sequencer
    import jtsq_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_valid,
    output wire logic        s_ready,
    input  wire logic [2:0]  s_op,
    input  wire logic [63:0] s_payload,
    input  wire logic [6:0]  s_bit_count,
    input  wire logic        s_end_in_pause,
    input  wire logic        s_tdo_sample,

    output wire logic        m_valid,
    input  wire logic        m_ready,
    output wire logic        m_clock_pulse,
    output wire logic        m_tms_level,
    output wire logic        m_tdi_level,
    output wire logic        m_busy_res,
    output wire logic        m_finished,
    output wire logic [1:0]  m_status,
    output wire logic [63:0] m_captured_bits,
    output wire logic [1:0]  m_tap_position
);

    // Request register (stage one).
    logic        in_valid_reg;
    logic [2:0]  op_reg;
    logic [63:0] payload_reg;
    logic [6:0]  bit_count_reg;
    logic        end_in_pause_reg;
    logic        tdo_sample_reg;

    // Sequencer state, updated only when a request moves into the result register.
    jtsq_state_t state_reg;
    jtsq_state_t state_next;

    // Result register (stage two).
    logic      out_valid_reg;
    jtsq_res_t res_reg;
    jtsq_res_t res_next;

    logic out_free;
    logic advance;

    // The result register takes a new entry when empty or being drained;
    // the request register refills whenever it moves forward.
    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    jtsq_step u_step (
        .op           (op_reg),
        .payload      (payload_reg),
        .bit_count    (bit_count_reg),
        .end_in_pause (end_in_pause_reg),
        .tdo_sample   (tdo_sample_reg),
        .state        (state_reg),
        .state_next   (state_next),
        .res          (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg           <= s_op;
            payload_reg      <= s_payload;
            bit_count_reg    <= s_bit_count;
            end_in_pause_reg <= s_end_in_pause;
            tdo_sample_reg   <= s_tdo_sample;
        end
    end

    // Sequencer state: one step per request that leaves stage one.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_clock_pulse   = res_reg.clock_pulse;
    assign m_tms_level     = res_reg.tms_level;
    assign m_tdi_level     = res_reg.tdi_level;
    assign m_busy_res      = res_reg.busy_res;
    assign m_finished      = res_reg.finished;
    assign m_status        = res_reg.status;
    assign m_captured_bits = res_reg.captured_bits;
    assign m_tap_position  = res_reg.tap_position;

    // A command's last clock is a real clock and leaves the sequencer idle.
    `JTSQ_ASSERT(a_fin_has_clock, aclk, aresetn,
        (out_valid_reg && res_reg.finished) |-> (res_reg.clock_pulse && !res_reg.busy_res),
        "finished without clock or still busy")
    // Rejected requests never drive TCK.
    `JTSQ_ASSERT(a_reject_no_clock, aclk, aresetn,
        (out_valid_reg && res_reg.status != ST_OK) |-> !res_reg.clock_pulse,
        "clock on rejected request")
    // The sequencer state only moves with a request.
    `JTSQ_ASSERT_NEXT(a_state_holds, aclk, aresetn, !advance, $stable(state_reg),
        "state changed without a request")
    // A stalled result leaves the state alone.
    `JTSQ_ASSERT_NEXT(a_stall_holds, aclk, aresetn, out_valid_reg && !m_ready,
        $stable(res_reg) && $stable(state_reg), "result or state moved during stall")

endmodule
`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the JTAG TAP scan sequencer, with a cycle-level request predictor.
`timescale 1ns / 1ps
module tb_top;
    import jtsq_pkg::*;

    // Run sizing.
    localparam int RANDOM_REQS    = 1900;
    localparam int HOLD_CYCLES    = 150;   // long receiver hold-off in the pressure test
    localparam int WATCHDOG_LIMIT = 3000;  // cycles with no handshake on either side
    localparam int DRAIN_CYCLES   = 8;     // spare cycles after the last result is checked
    localparam int MAX_PRINTED    = 40;

    // Predicted sequencer state, kept in step with accepted requests.
    typedef struct packed {
        logic [1:0]  tap;        // tracked TAP position
        jtsq_phase_t phase;
        logic [31:0] tms_bits;   // TMS still to send, LSB first
        logic [5:0]  tms_left;
        logic [63:0] tdi_bits;   // TDI still to shift, LSB first
        logic [6:0]  data_left;
        logic [63:0] tdo_bits;   // TDO captured so far
        logic [5:0]  tdo_pos;
        logic [1:0]  exit_tap;   // TAP position once the command finishes
    } scan_track_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;

    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_op = OP_TICK;
    logic [63:0] s_payload = '0;
    logic [6:0]  s_bit_count = '0;
    logic        s_end_in_pause = 1'b0;
    logic        s_tdo_sample = 1'b0;

    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_clock_pulse;
    logic        m_tms_level;
    logic        m_tdi_level;
    logic        m_busy_res;
    logic        m_finished;
    logic [1:0]  m_status;
    logic [63:0] m_captured_bits;
    logic [1:0]  m_tap_position;

    scan_track_t tap_model = '0;
    jtsq_res_t   pending_results[$];

    int reqs_sent = 0;
    int meaningful_reqs = 0;   // requests other than the ignored op codes
    int tick_reqs = 0;
    int results_seen = 0;
    int mismatches = 0;
    int cmds_finished = 0;
    int busy_rejects = 0;
    int range_rejects = 0;
    int holds_done = 0;
    int burst_left = 0;
    int quiet_cycles = 0;
    bit no_gaps = 1'b0;
    bit hold_req = 1'b0;

    jtag_tap_scan_sequencer dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_payload       (s_payload),
        .s_bit_count     (s_bit_count),
        .s_end_in_pause  (s_end_in_pause),
        .s_tdo_sample    (s_tdo_sample),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_clock_pulse   (m_clock_pulse),
        .m_tms_level     (m_tms_level),
        .m_tdi_level     (m_tdi_level),
        .m_busy_res      (m_busy_res),
        .m_finished      (m_finished),
        .m_status        (m_status),
        .m_captured_bits (m_captured_bits),
        .m_tap_position  (m_tap_position)
    );

    // 12 ns clock.
    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Applies one request to the predicted state and returns the result it should produce.
    // Busy and capture outputs reflect the state after the request.
    function automatic jtsq_res_t advance_sequencer(input logic [2:0] op, input logic [63:0] bits,
                                                    input logic [6:0] count, input logic pause,
                                                    input logic tdo);
        jtsq_res_t r;
        logic      clk_o, tms_o, tdi_o, fin_o;
        logic [1:0] st;
        logic      from_pause;
        clk_o = 1'b0;
        tms_o = 1'b0;
        tdi_o = 1'b0;
        fin_o = 1'b0;
        st = ST_OK;
        from_pause = (tap_model.tap >= TAP_PAUSE_DR);
        if (op == OP_TICK) begin
            if (tap_model.phase == PH_DATA) begin
                clk_o = 1'b1;
                tdi_o = tap_model.tdi_bits[0];
                tap_model.tdi_bits = tap_model.tdi_bits >> 1;
                // TDO is captured on every data clock, the last one included
                if (tdo)
                    tap_model.tdo_bits[tap_model.tdo_pos] = 1'b1;
                tap_model.tdo_pos = tap_model.tdo_pos + 6'd1;
                tap_model.data_left = tap_model.data_left - 7'd1;
                if (tap_model.data_left == 7'd0) begin
                    // last data bit leaves Shift with TMS high
                    tms_o = 1'b1;
                    tap_model.phase = PH_EXIT;
                    if (tap_model.exit_tap == TAP_IDLE) begin
                        tap_model.tms_bits = TMS_EXIT_IDLE;
                        tap_model.tms_left = LEN_EXIT_IDLE;
                    end else begin
                        tap_model.tms_bits = TMS_EXIT_PAUSE;
                        tap_model.tms_left = LEN_EXIT_PAUSE;
                    end
                end
            end else if (tap_model.phase != PH_IDLE) begin
                clk_o = 1'b1;
                tms_o = tap_model.tms_bits[0];
                tap_model.tms_bits = tap_model.tms_bits >> 1;
                tap_model.tms_left = tap_model.tms_left - 6'd1;
                if (tap_model.tms_left == 6'd0) begin
                    if (tap_model.phase == PH_ENTRY && tap_model.data_left != 7'd0) begin
                        tap_model.phase = PH_DATA;
                    end else begin
                        tap_model.phase = PH_IDLE;
                        tap_model.tap = tap_model.exit_tap;
                        fin_o = 1'b1;
                    end
                end
            end
        end else if (op <= OP_RAW_TMS) begin
            if (tap_model.phase != PH_IDLE) begin
                st = ST_BUSY;
            end else begin
                case (op)
                    OP_DR_SCAN, OP_IR_SCAN: begin
                        if (count == 7'd0 || count > MAX_SCAN_BITS) begin
                            st = ST_RANGE;
                        end else begin
                            if (op == OP_DR_SCAN) begin
                                tap_model.tms_bits = from_pause ? TMS_DR_FROM_PAUSE
                                                                : TMS_DR_FROM_IDLE;
                                tap_model.tms_left = from_pause ? LEN_DR_FROM_PAUSE
                                                                : LEN_DR_FROM_IDLE;
                                tap_model.exit_tap = pause ? TAP_PAUSE_DR : TAP_IDLE;
                            end else begin
                                tap_model.tms_bits = from_pause ? TMS_IR_FROM_PAUSE
                                                                : TMS_IR_FROM_IDLE;
                                tap_model.tms_left = from_pause ? LEN_IR_FROM_PAUSE
                                                                : LEN_IR_FROM_IDLE;
                                tap_model.exit_tap = pause ? TAP_PAUSE_IR : TAP_IDLE;
                            end
                            tap_model.tdi_bits = bits;
                            tap_model.data_left = count;
                            tap_model.tdo_bits = '0;
                            tap_model.tdo_pos = '0;
                            tap_model.phase = PH_ENTRY;
                        end
                    end
                    OP_TAP_RST: begin
                        tap_model.tms_bits = TMS_TAP_RESET;
                        tap_model.tms_left = LEN_TAP_RESET;
                        tap_model.data_left = '0;
                        tap_model.exit_tap = TAP_RESET;
                        tap_model.phase = PH_EXIT;
                    end
                    default: begin
                        if (count > MAX_TMS_BITS) begin
                            st = ST_RANGE;
                        end else if (count != 7'd0) begin
                            tap_model.tms_bits = bits[31:0];
                            tap_model.tms_left = count[5:0];
                            tap_model.data_left = '0;
                            tap_model.exit_tap = tap_model.tap;
                            tap_model.phase = PH_EXIT;
                        end
                    end
                endcase
            end
        end
        r.clock_pulse = clk_o;
        r.tms_level = tms_o;
        r.tdi_level = tdi_o;
        r.busy_res = (tap_model.phase != PH_IDLE);
        r.finished = fin_o;
        r.status = st;
        r.captured_bits = tap_model.tdo_bits;
        r.tap_position = tap_model.tap;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("mismatch at result %0d (%0t): %s got %h want %h",
                     results_seen, $time, what, got, want);
    endtask

    // Sends one request. The sender runs in bursts; between bursts valid may drop for a while.
    // Valid is left high after acceptance so back-to-back requests never toggle it.
    task automatic send_req(input logic [2:0] op, input logic [63:0] bits,
                            input logic [6:0] count, input logic pause, input logic tdo);
        int        gap;
        jtsq_res_t want;
        if (!no_gaps && burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            if (gap > 0) begin
                @(negedge aclk);
                s_valid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        if (burst_left > 0)
            burst_left--;
        @(negedge aclk);
        s_valid <= 1'b1;
        s_op <= op;
        s_payload <= bits;
        s_bit_count <= count;
        s_end_in_pause <= pause;
        s_tdo_sample <= tdo;
        do @(posedge aclk); while (!s_ready);
        want = advance_sequencer(op, bits, count, pause, tdo);
        pending_results.push_back(want);
        reqs_sent++;
        if (op <= OP_RAW_TMS)
            meaningful_reqs++;
        if (op == OP_TICK)
            tick_reqs++;
        if (want.finished)
            cmds_finished++;
        if (want.status == ST_BUSY)
            busy_rejects++;
        if (want.status == ST_RANGE)
            range_rejects++;
    endtask

    // Tick with random TDO; the unused fields carry junk.
    task automatic send_tick();
        send_req(OP_TICK, rand64(), 7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)));
    endtask

    // Ticks until the predicted sequencer is idle; optionally slips in commands while busy.
    task automatic run_to_idle(input bit with_rejects);
        while (tap_model.phase != PH_IDLE) begin
            if (with_rejects && $urandom_range(0, 11) == 0)
                send_req(3'($urandom_range(OP_DR_SCAN, OP_RAW_TMS)), rand64(),
                         7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
            else
                send_tick();
        end
    endtask

    task automatic send_random_scan();
        logic [6:0] len;
        case ($urandom_range(0, 9))
            0, 1:    len = 7'd64;
            2, 3, 4: len = 7'($urandom_range(1, 64));
            default: len = 7'($urandom_range(1, 8));
        endcase
        send_req($urandom_range(0, 1) ? OP_DR_SCAN : OP_IR_SCAN, rand64(), len,
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    // Tick while idle and the three unused op codes: no clock, status ok.
    task automatic test_idle_ops();
        send_req(OP_TICK, '1, 7'd127, 1'b1, 1'b1);
        send_req(3'd5, '1, 7'd127, 1'b1, 1'b1);
        send_req(3'd6, '0, 7'd0, 1'b0, 1'b0);
        send_req(3'd7, rand64(), 7'd64, 1'b1, 1'b0);
    endtask

    // Bad lengths are refused; a raw sequence of zero bits is accepted and does nothing.
    task automatic test_range_checks();
        send_req(OP_DR_SCAN, '1, 7'd0, 1'b0, 1'b1);
        send_req(OP_IR_SCAN, '1, 7'd65, 1'b1, 1'b0);
        send_req(OP_DR_SCAN, '1, 7'd127, 1'b1, 1'b1);
        send_req(OP_RAW_TMS, '1, 7'd32, 1'b0, 1'b0);
        send_req(OP_RAW_TMS, '1, 7'd0, 1'b0, 1'b1);
    endtask

    // TAP reset with a command rejected while its clocks are still going out.
    task automatic test_tap_reset();
        send_req(OP_TAP_RST, '0, 7'd0, 1'b0, 1'b0);
        send_tick();
        send_req(OP_IR_SCAN, rand64(), 7'd8, 1'b0, 1'b1);
        run_to_idle(1'b0);
    endtask

    // Shortest DR scan, ending in Pause-DR, with the single TDO bit set.
    task automatic test_short_dr_scan();
        send_req(OP_DR_SCAN, '1, 7'd1, 1'b1, 1'b0);
        while (tap_model.phase != PH_IDLE)
            send_req(OP_TICK, '0, 7'd0, 1'b0, 1'b1);
    endtask

    task automatic test_raw_tms();
        send_req(OP_RAW_TMS, 64'h1, 7'd1, 1'b0, 1'b0);
        send_tick();
    endtask

    // Mostly complete command sequences with random content, the rest noise.
    task automatic test_random_traffic();
        int start;
        int pick;
        int n;
        start = meaningful_reqs;
        while (meaningful_reqs - start < RANDOM_REQS) begin
            pick = $urandom_range(0, 99);
            if (pick < 75)
                run_to_idle(1'b1);
            if (pick < 50) begin
                send_random_scan();
            end else if (pick < 60) begin
                send_req(OP_TAP_RST, rand64(), 7'($urandom_range(0, 127)),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end else if (pick < 75) begin
                send_req(OP_RAW_TMS, rand64(), 7'($urandom_range(1, MAX_TMS_BITS)),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end else begin
                // noise: any op, any length, possibly mid-command
                n = $urandom_range(1, 4);
                repeat (n)
                    send_req(3'($urandom_range(0, 7)), rand64(), 7'($urandom_range(0, 127)),
                             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
            if (pick < 75)
                run_to_idle(1'b1);
            if ($urandom_range(0, 7) == 0)
                send_tick();
        end
        run_to_idle(1'b0);
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering a full-length scan.
    task automatic test_backpressure();
        no_gaps = 1'b1;
        hold_req = 1'b1;
        send_req(OP_IR_SCAN, rand64(), 7'd64, 1'b0, 1'($urandom_range(0, 1)));
        run_to_idle(1'b0);
        send_req(OP_DR_SCAN, rand64(), 7'd64, 1'b1, 1'($urandom_range(0, 1)));
        run_to_idle(1'b0);
        no_gaps = 1'b0;
    endtask

    // Receiver: random-length segments of always ready, coin flip, fixed pattern or
    // mostly stalled; a long hold-off is inserted when a test asks for one.
    initial begin : rx_stall
        int seg_left;
        int mode;
        int cyc;
        seg_left = 0;
        mode = 0;
        cyc = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
                holds_done++;
            end
            if (seg_left == 0) begin
                mode = $urandom_range(0, 3);
                seg_left = $urandom_range(8, 64);
            end
            seg_left--;
            cyc++;
            case (mode)
                0: m_ready <= 1'b1;
                1: m_ready <= 1'($urandom_range(0, 1));
                2: m_ready <= ((cyc % 4) != 3);
                default: m_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Result checker: every accepted result against the oldest prediction.
    always @(posedge aclk) begin : result_check
        jtsq_res_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending", '0, '0);
            end else begin
                want = pending_results.pop_front();
                if (m_clock_pulse !== want.clock_pulse)
                    report_mismatch("clock_pulse", 64'(m_clock_pulse), 64'(want.clock_pulse));
                if (m_tms_level !== want.tms_level)
                    report_mismatch("tms_level", 64'(m_tms_level), 64'(want.tms_level));
                if (m_tdi_level !== want.tdi_level)
                    report_mismatch("tdi_level", 64'(m_tdi_level), 64'(want.tdi_level));
                if (m_busy_res !== want.busy_res)
                    report_mismatch("busy_res", 64'(m_busy_res), 64'(want.busy_res));
                if (m_finished !== want.finished)
                    report_mismatch("finished", 64'(m_finished), 64'(want.finished));
                if (m_status !== want.status)
                    report_mismatch("status", 64'(m_status), 64'(want.status));
                if (m_captured_bits !== want.captured_bits)
                    report_mismatch("captured_bits", m_captured_bits, want.captured_bits);
                if (m_tap_position !== want.tap_position)
                    report_mismatch("tap_position", 64'(m_tap_position), 64'(want.tap_position));
            end
        end
    end

    // Watchdog: ends the run after too long without a handshake on either side.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d results pending",
                     WATCHDOG_LIMIT, pending_results.size());
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        test_idle_ops();
        test_range_checks();
        test_tap_reset();
        test_short_dr_scan();
        test_raw_tms();
        test_random_traffic();
        test_backpressure();

        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("run covered %0d requests (%0d ticks), %0d results checked, %0d commands done",
                 reqs_sent, tick_reqs, results_seen, cmds_finished);
        $display("rejects: %0d busy, %0d bad length; long receiver hold-offs: %0d; mismatches: %0d",
                 busy_rejects, range_rejects, holds_done, mismatches);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
